>>> rtl/frame_time_statistics_defines.svh
// Assertion helpers for the asserting module.
`ifndef FRAME_TIME_STATISTICS_DEFINES_SVH
`define FRAME_TIME_STATISTICS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/fts_pkg.sv
`timescale 1ns / 1ps
package fts_pkg;

  localparam int FT_W       = 24;
  localparam int RATE_W     = 26;
  localparam int AVG_W      = 27;
  localparam int CNT_W      = 32;
  localparam int WGT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int WINDOW_DEPTH_DEF = 64;

  // Shared divider geometry: dividend {f, 16'b0}, divisor up to {f, 1'b0}.
  localparam int DVD_W = 40;
  localparam int DSR_W = 25;

  // Twice 65536000: rate numerator before the rounding term.
  localparam logic [27:0] RATE_NUM2  = 28'd131072000;
  localparam logic [42:0] ROUND_HALF = 43'd32768;

  localparam logic [FT_W-1:0]  THRESH_RST = 24'd12800;
  localparam logic [FT_W-1:0]  WINDOW_RST = 24'd256000;
  localparam logic [WGT_W-1:0] LIMIT_RST  = 16'd32768;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 2'd2;

  typedef struct packed {
    logic            done;
    logic [FT_W-1:0] top1;
    logic [FT_W-1:0] top4;
  } scan_res_t;

endpackage

>>> rtl/fts_if.sv
`timescale 1ns / 1ps
interface fts_in_if;
  import fts_pkg::*;
  logic            valid;
  logic            ready;
  logic [FT_W-1:0] frame_time;
  logic [FT_W-1:0] swap_time;
  modport source (output valid, frame_time, swap_time, input ready);
  modport sink   (input valid, frame_time, swap_time, output ready);
endinterface

interface fts_out_if;
  import fts_pkg::*;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] rate_average;
  logic [FT_W-1:0]   last_frame_time;
  logic [FT_W-1:0]   slow_percentile_time;
  logic [FT_W-1:0]   last_swap_time;
  logic [CNT_W-1:0]  long_frames;
  logic [CNT_W-1:0]  total_frames;
  modport source (output valid, rate_average, last_frame_time, slow_percentile_time,
                  last_swap_time, long_frames, total_frames, input ready);
  modport sink   (input valid, rate_average, last_frame_time, slow_percentile_time,
                  last_swap_time, long_frames, total_frames, output ready);
endinterface

>>> rtl/frame_time_statistics.sv
`timescale 1ns / 1ps
// Frame time statistics.
// in_chan carries one frame time and one swap time per item (Q16.8 ms);
// out_chan returns one result per nonzero frame time: smoothed rate, the
// frame and swap times, the slow percentile and both frame counters.
// An item with a zero frame time is accepted and dropped without a result.
// cfg_we/cfg_index/cfg_data write the threshold, average window and weight
// limit; write them only while the block is idle.
// Order: the ring write starts the ring scan, which runs beside the rate
// division on the shared bit-serial divider; then the weight division, the
// averaging multiply, the average update and the output register load
// follow. One item is in work at a time, so the next item is taken only
// after the last one has loaded the output register.
// in_chan.ready is high while idle; the next item is taken even while a
// result still waits in the output register. If the receiver stalls, the
// finished item waits for the output register to drain before it loads.
// Reset clears counters, fill count, write slot and the average; the ring
// memory is not cleared, as only written entries are ever scanned.
module frame_time_statistics #(
  parameter int WINDOW_DEPTH = fts_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fts_in_if.sink                         in_chan,
  fts_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [fts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fts_pkg::*;
  `include "frame_time_statistics_defines.svh"

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WDIV  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_AVG   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;

  logic [FT_W-1:0]  thr_r, win_r;
  logic [WGT_W-1:0] lim_r;

  logic [FT_W-1:0]   f_r, s_r, slow_r;
  logic [AW-1:0]     slot_r;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [AVG_W-1:0]  avg_r, avg_nxt, diff;
  logic [RATE_W-1:0] rate_r;
  logic [WGT_W-1:0]  w_r, w_nxt;
  logic [42:0]       prod_r;
  logic [27:0]       step;
  logic              ge, scan_ok_r, rate_ok_r;
  logic [CNT_W-1:0]  long_r, total_r;

  logic              div_start;
  logic [DVD_W-1:0]  div_dvd, div_q;
  logic [DSR_W-1:0]  div_dsr;
  logic              div_done;
  scan_res_t         scan_res;

  logic              out_valid_r;
  logic [RATE_W-1:0] o_rate_r;
  logic [FT_W-1:0]   o_f_r, o_slow_r, o_s_r;
  logic [CNT_W-1:0]  o_long_r, o_total_r;
  logic              out_free, in_fire;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RST;
      win_r <= WINDOW_RST;
      lim_r <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r <= cfg_data;
        REG_WINDOW:    win_r <= cfg_data;
        REG_LIMIT:     lim_r <= cfg_data[WGT_W-1:0];
        default:       ;
      endcase
    end
  end

  assign fill_nxt = (fill_r < CW'(WINDOW_DEPTH)) ? fill_r + 1'b1 : fill_r;

  // Rate division starts with the ring write, weight division after it.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = {{(DVD_W-28){1'b0}}, RATE_NUM2 + {4'b0, f_r}};
    div_dsr   = {f_r, 1'b0};
    if (state_r == S_WRITE) begin
      div_start = 1'b1;
    end else if (state_r == S_SCAN && scan_ok_r && rate_ok_r) begin
      div_start = 1'b1;
      div_dvd   = {f_r, 16'b0};
      div_dsr   = {1'b0, win_r};
    end
  end

  fts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  fts_scan #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (state_r == S_WRITE),
    .wr_addr (slot_r),
    .wr_data (f_r),
    .start   (state_r == S_WRITE),
    .count   (fill_nxt),
    .res     (scan_res)
  );

  // Cap the weight; a zero window takes the limit.
  assign w_nxt = (win_r == '0 || div_q > {{(DVD_W-WGT_W){1'b0}}, lim_r}) ?
                 lim_r : div_q[WGT_W-1:0];

  assign ge   = {1'b0, rate_r} >= avg_r;
  assign diff = ge ? ({1'b0, rate_r} - avg_r) : (avg_r - {1'b0, rate_r});
  assign step = 28'((prod_r + ROUND_HALF) >> 16);

  always_comb begin
    if (avg_r == '0) avg_nxt = {1'b0, rate_r};
    else if (ge)     avg_nxt = avg_r + step[AVG_W-1:0];
    else             avg_nxt = avg_r - step[AVG_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire && in_chan.frame_time != '0) state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_SCAN;
      S_SCAN:  if (scan_ok_r && rate_ok_r) state_nxt = S_WDIV;
      S_WDIV:  if (div_done) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_AVG;
      S_AVG:   state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      slot_r    <= '0;
      fill_r    <= '0;
      avg_r     <= '0;
      long_r    <= '0;
      total_r   <= '0;
      scan_ok_r <= 1'b0;
      rate_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_WRITE) begin
        slot_r    <= (slot_r == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        fill_r    <= fill_nxt;
        scan_ok_r <= 1'b0;
        rate_ok_r <= 1'b0;
      end
      if (state_r == S_SCAN && scan_res.done) scan_ok_r <= 1'b1;
      if (state_r == S_SCAN && div_done)      rate_ok_r <= 1'b1;
      if (state_r == S_AVG) begin
        avg_r   <= avg_nxt;
        total_r <= total_r + 1'b1;
        if (f_r > thr_r) long_r <= long_r + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      f_r <= in_chan.frame_time;
      s_r <= in_chan.swap_time;
    end
    if (state_r == S_SCAN && scan_res.done)
      slow_r <= (fill_r == CW'(WINDOW_DEPTH)) ? scan_res.top4 : scan_res.top1;
    if (state_r == S_SCAN && div_done) rate_r <= div_q[RATE_W-1:0];
    if (state_r == S_WDIV && div_done) w_r <= w_nxt;
    if (state_r == S_MUL) prod_r <= 43'(w_r * diff);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      o_rate_r  <= avg_r[RATE_W-1:0];
      o_f_r     <= f_r;
      o_slow_r  <= slow_r;
      o_s_r     <= s_r;
      o_long_r  <= long_r;
      o_total_r <= total_r;
    end
  end

  assign out_chan.valid                = out_valid_r;
  assign out_chan.rate_average         = o_rate_r;
  assign out_chan.last_frame_time      = o_f_r;
  assign out_chan.slow_percentile_time = o_slow_r;
  assign out_chan.last_swap_time       = o_s_r;
  assign out_chan.long_frames          = o_long_r;
  assign out_chan.total_frames         = o_total_r;

  `FTS_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CW'(WINDOW_DEPTH), "fill count over depth")
  `FTS_ASSERT_NOW(a_scan_in_state, scan_res.done, state_r == S_SCAN, "scan done out of place")
  `FTS_ASSERT_NEXT(a_avg_sticky, avg_r != '0, avg_r != '0, "average fell back to zero")
endmodule

>>> rtl/fts_div.sv
`timescale 1ns / 1ps
module fts_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fts_pkg::DVD_W-1:0] dividend,
  input  logic [fts_pkg::DSR_W-1:0] divisor,
  output logic                      done,
  output logic [fts_pkg::DVD_W-1:0] quotient
);
  import fts_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DSR_W-1:0] dsr_r, rem_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r, done_r;
  logic [DSR_W:0]   rem_sh, diff;

  // One quotient bit per cycle, restoring form.
  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!diff[DSR_W]) begin
        rem_r <= diff[DSR_W-1:0];
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DSR_W-1:0];
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;
endmodule

>>> rtl/fts_scan.sv
`timescale 1ns / 1ps
module fts_scan #(
  parameter int WINDOW_DEPTH = fts_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [$clog2(WINDOW_DEPTH)-1:0] wr_addr,
  input  logic [fts_pkg::FT_W-1:0]        wr_data,
  input  logic                            start,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0] count,
  output fts_pkg::scan_res_t              res
);
  import fts_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  logic [FT_W-1:0] ring_mem [WINDOW_DEPTH];
  logic [FT_W-1:0] rd_data_r;
  logic [AW-1:0]   idx_r;
  logic [CW-1:0]   count_r;
  logic            active_r, rd_valid_r, rd_last_r, done_r, is_last;
  logic [FT_W-1:0] t1_r, t2_r, t3_r, t4_r;

  assign is_last = ({{(CW-AW){1'b0}}, idx_r} == count_r - 1'b1);

  always_ff @(posedge clk) begin
    if (wr_en) ring_mem[wr_addr] <= wr_data;
    if (active_r) rd_data_r <= ring_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      rd_valid_r <= 1'b0;
      rd_last_r  <= 1'b0;
      done_r     <= 1'b0;
      idx_r      <= '0;
      count_r    <= '0;
    end else begin
      rd_valid_r <= active_r;
      rd_last_r  <= active_r && is_last;
      done_r     <= rd_valid_r && rd_last_r;
      if (start) begin
        active_r <= 1'b1;
        idx_r    <= '0;
        count_r  <= count;
      end else if (active_r) begin
        idx_r <= idx_r + 1'b1;
        if (is_last) active_r <= 1'b0;
      end
    end
  end

  // Keep the four largest, duplicates counted.
  always_ff @(posedge clk) begin
    if (start) begin
      t1_r <= '0;
      t2_r <= '0;
      t3_r <= '0;
      t4_r <= '0;
    end else if (rd_valid_r) begin
      if (rd_data_r > t1_r) begin
        t4_r <= t3_r; t3_r <= t2_r; t2_r <= t1_r; t1_r <= rd_data_r;
      end else if (rd_data_r > t2_r) begin
        t4_r <= t3_r; t3_r <= t2_r; t2_r <= rd_data_r;
      end else if (rd_data_r > t3_r) begin
        t4_r <= t3_r; t3_r <= rd_data_r;
      end else if (rd_data_r > t4_r) begin
        t4_r <= rd_data_r;
      end
    end
  end

  assign res.done = done_r;
  assign res.top1 = t1_r;
  assign res.top4 = t4_r;
endmodule
